@@ sv/sdgp_pkg.sv @@
// ---------------------------------------------------------------------------
// Second-difference group packer package
// Shared widths, constants, payload structs, controller states and the
// command and status structs between the controller and the datapath.
// ---------------------------------------------------------------------------
package sdgp_pkg;

  // Geometry of the group buffer and of the packing accumulator.
  localparam int unsigned GROUP_LEN  = 32;
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned WCODE_W    = 4;
  localparam int unsigned ACC_W      = WORD_W + SAMPLE_W;
  localparam int unsigned FILL_W     = $clog2(GROUP_LEN + 1);
  localparam int unsigned ADDR_W     = $clog2(GROUP_LEN);
  localparam int unsigned NBITS_W    = $clog2(ACC_W);

  // Arithmetic constants.
  localparam logic [SAMPLE_W-1:0] DIFF_OFFSET = 16'h8000;
  localparam logic [SAMPLE_W-1:0] MIN_INIT    = 16'hFFFF;
  localparam logic [SAMPLE_W-1:0] MAX_INIT    = 16'h0000;
  localparam logic [1:0]          LEAD_DONE   = 2'd2;
  localparam logic [NBITS_W-1:0]  WORD_BITS   = NBITS_W'(WORD_W);

  // Result item kinds.
  localparam logic KIND_HEADER = 1'b0;
  localparam logic KIND_DATA   = 1'b1;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                final_req;
  } sdgp_in_t;

  typedef struct packed {
    logic                kind;
    logic [SAMPLE_W-1:0] min_ref;
    logic [WCODE_W-1:0]  width_code;
    logic [WORD_W-1:0]   data_word;
    logic                group_end;
    logic                set_end;
  } sdgp_out_t;

  typedef enum logic [2:0] {
    ST_COLLECT,
    ST_HEAD,
    ST_READ,
    ST_MERGE,
    ST_WORD,
    ST_FLUSH
  } sdgp_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;   // accept an input sample
    logic head;   // load the group header into the output register
    logic merge;  // merge one stored value into the accumulator
    logic word;   // emit a full accumulator word
    logic flush;  // emit the padded final word of the group
  } sdgp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic close_hit;   // the offered sample closes the group
    logic merge_full;  // the merge in progress fills at least one word
    logic last;        // the value being merged is the last of the group
    logic last_q;      // the last value has been merged
    logic word_done;   // the pending word is the last item of the group
    logic out_free;    // the output register can take an item
  } sdgp_sts_t;

endpackage

@@ sv/sdgp_ram.sv @@
// ---------------------------------------------------------------------------
// Generic RAM
// Single write port and single read port, with a registered read.
// ---------------------------------------------------------------------------
module sdgp_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/sdgp_ctrl.sv @@
// ---------------------------------------------------------------------------
// Second-difference group packer controller
// Sequences sample collection, the group header and the packing of the
// stored values into words.
// ---------------------------------------------------------------------------
module sdgp_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  sdgp_pkg::sdgp_sts_t sts_i,
  output sdgp_pkg::sdgp_cmd_t cmd_o
);

  sdgp_pkg::sdgp_state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sdgp_pkg::ST_COLLECT;
    end else begin
      state_q <= state_d;
    end
  end

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    case (state_q)
      sdgp_pkg::ST_COLLECT: begin
        if (in_valid_i && sts_i.close_hit) begin
          state_d = sdgp_pkg::ST_HEAD;
        end
      end
      sdgp_pkg::ST_HEAD: begin
        if (sts_i.out_free) begin
          state_d = sdgp_pkg::ST_READ;
        end
      end
      sdgp_pkg::ST_READ: begin
        state_d = sdgp_pkg::ST_MERGE;
      end
      sdgp_pkg::ST_MERGE: begin
        if (sts_i.merge_full) begin
          state_d = sdgp_pkg::ST_WORD;
        end else if (sts_i.last) begin
          state_d = sdgp_pkg::ST_FLUSH;
        end else begin
          state_d = sdgp_pkg::ST_READ;
        end
      end
      sdgp_pkg::ST_WORD: begin
        if (sts_i.out_free) begin
          if (sts_i.word_done) begin
            state_d = sdgp_pkg::ST_COLLECT;
          end else if (sts_i.last_q) begin
            state_d = sdgp_pkg::ST_FLUSH;
          end else begin
            state_d = sdgp_pkg::ST_READ;
          end
        end
      end
      sdgp_pkg::ST_FLUSH: begin
        if (sts_i.out_free) begin
          state_d = sdgp_pkg::ST_COLLECT;
        end
      end
      default: begin
        state_d = sdgp_pkg::ST_COLLECT;
      end
    endcase
  end

  // Output logic: input samples are taken only while collecting.
  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      sdgp_pkg::ST_COLLECT: begin
        in_stall_o = 1'b0;
        cmd_o.take = in_valid_i;
      end
      sdgp_pkg::ST_HEAD: begin
        cmd_o.head = sts_i.out_free;
      end
      sdgp_pkg::ST_READ: begin
        cmd_o = '0;
      end
      sdgp_pkg::ST_MERGE: begin
        cmd_o.merge = 1'b1;
      end
      sdgp_pkg::ST_WORD: begin
        cmd_o.word = sts_i.out_free;
      end
      sdgp_pkg::ST_FLUSH: begin
        cmd_o.flush = sts_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

@@ sv/sdgp_dp.sv @@
// ---------------------------------------------------------------------------
// Second-difference group packer datapath
// Forms the offset second differences, keeps the group buffer and its
// extremes, and packs the offsets from the minimum into 32-bit words.
// ---------------------------------------------------------------------------
module sdgp_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sdgp_pkg::sdgp_in_t  in_item_i,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output sdgp_pkg::sdgp_out_t out_item_o,
  input  sdgp_pkg::sdgp_cmd_t cmd_i,
  output sdgp_pkg::sdgp_sts_t sts_o
);

  localparam int unsigned SW = sdgp_pkg::SAMPLE_W;
  localparam int unsigned WW = sdgp_pkg::WORD_W;
  localparam int unsigned AW = sdgp_pkg::ACC_W;
  localparam int unsigned FW = sdgp_pkg::FILL_W;
  localparam int unsigned NW = sdgp_pkg::NBITS_W;
  localparam int unsigned CW = sdgp_pkg::WCODE_W;

  // Differencing and group tracking state.
  logic [SW-1:0] prev_q, older_q;
  logic [1:0]    lead_q;
  logic [FW-1:0] fill_q;
  logic [SW-1:0] min_q, max_q;
  logic          fin_q;

  // Packing state.
  logic [FW-1:0] rd_idx_q;
  logic [CW-1:0] wc_q;
  logic [AW-1:0] acc_q;
  logic [NW-1:0] nbits_q;
  logic          last_q;

  // Output register.
  logic                out_valid_q;
  sdgp_pkg::sdgp_out_t out_item_q;

  logic [SW-1:0] code;
  logic [FW-1:0] fill_next;
  logic [FW-1:0] rd_next;
  logic [SW-1:0] range_val;
  logic [CW-1:0] wc_calc;
  logic [SW-1:0] ram_rdata;
  logic [SW-1:0] offset;
  logic [SW-1:0] val_al;
  logic [NW-1:0] nbits_sum;
  logic [AW-1:0] acc_merged;
  logic          last_val;
  logic          word_done;
  logic          out_free;
  logic          out_load;
  logic          finish;

  // Offset second difference; the leading two samples pass with the offset only.
  always_comb begin
    if (lead_q < sdgp_pkg::LEAD_DONE) begin
      code = in_item_i.sample + sdgp_pkg::DIFF_OFFSET;
    end else begin
      code = in_item_i.sample - {prev_q[SW-2:0], 1'b0} + older_q
             + sdgp_pkg::DIFF_OFFSET;
    end
  end

  assign fill_next = fill_q + FW'(1);
  assign rd_next   = rd_idx_q + FW'(1);
  assign last_val  = (rd_next == fill_q);

  // Width code: position of the highest set bit of the group range.
  assign range_val = max_q - min_q;
  always_comb begin
    wc_calc = '0;
    for (int i = 0; i < SW; i++) begin
      if (range_val[i]) begin
        wc_calc = CW'(i);
      end
    end
  end

  // Offset from the minimum, aligned to the top of a 16-bit lane.
  assign offset     = ram_rdata - min_q;
  assign val_al     = offset << (CW'(SW - 1) - wc_q);
  assign nbits_sum  = nbits_q + NW'(wc_q) + NW'(1);
  assign acc_merged = acc_q | ({val_al, WW'(0)} >> nbits_q);
  assign word_done  = last_q && (nbits_q == sdgp_pkg::WORD_BITS);

  assign out_free = !out_valid_q || !out_stall_i;
  assign out_load = cmd_i.head || cmd_i.word || cmd_i.flush;
  assign finish   = cmd_i.flush || (cmd_i.word && word_done);

  // Group buffer.
  sdgp_ram #(
    .WIDTH(SW),
    .DEPTH(sdgp_pkg::GROUP_LEN)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (cmd_i.take),
    .waddr_i(fill_q[sdgp_pkg::ADDR_W-1:0]),
    .wdata_i(code),
    .raddr_i(rd_idx_q[sdgp_pkg::ADDR_W-1:0]),
    .rdata_o(ram_rdata)
  );

  // Differencing history, fill count and group extremes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= '0;
      older_q <= '0;
      lead_q  <= '0;
      fill_q  <= '0;
      min_q   <= sdgp_pkg::MIN_INIT;
      max_q   <= sdgp_pkg::MAX_INIT;
      fin_q   <= 1'b0;
    end else if (cmd_i.take) begin
      older_q <= prev_q;
      prev_q  <= in_item_i.sample;
      if (lead_q < sdgp_pkg::LEAD_DONE) begin
        lead_q <= lead_q + 2'd1;
      end
      fill_q <= fill_next;
      if (code < min_q) begin
        min_q <= code;
      end
      if (code > max_q) begin
        max_q <= code;
      end
      fin_q <= in_item_i.final_req;
    end else if (finish) begin
      fill_q <= '0;
      min_q  <= sdgp_pkg::MIN_INIT;
      max_q  <= sdgp_pkg::MAX_INIT;
      if (fin_q) begin
        prev_q  <= '0;
        older_q <= '0;
        lead_q  <= '0;
      end
    end
  end

  // Packing accumulator, kept left aligned with nbits_q valid bits on top.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_idx_q <= '0;
      wc_q     <= '0;
      acc_q    <= '0;
      nbits_q  <= '0;
      last_q   <= 1'b0;
    end else if (cmd_i.head) begin
      rd_idx_q <= '0;
      wc_q     <= wc_calc;
      acc_q    <= '0;
      nbits_q  <= '0;
      last_q   <= 1'b0;
    end else if (cmd_i.merge) begin
      rd_idx_q <= rd_next;
      acc_q    <= acc_merged;
      nbits_q  <= nbits_sum;
      last_q   <= last_val;
    end else if (cmd_i.word) begin
      acc_q   <= acc_q << WW;
      nbits_q <= nbits_q - sdgp_pkg::WORD_BITS;
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register payload: a header or a packed word.
  always_ff @(posedge clk_i) begin
    if (cmd_i.head) begin
      out_item_q.kind       <= sdgp_pkg::KIND_HEADER;
      out_item_q.min_ref    <= min_q;
      out_item_q.width_code <= wc_calc;
      out_item_q.data_word  <= '0;
      out_item_q.group_end  <= 1'b0;
      out_item_q.set_end    <= 1'b0;
    end else if (cmd_i.word || cmd_i.flush) begin
      out_item_q.kind       <= sdgp_pkg::KIND_DATA;
      out_item_q.min_ref    <= '0;
      out_item_q.width_code <= '0;
      out_item_q.data_word  <= acc_q[AW-1:AW-WW];
      out_item_q.group_end  <= finish;
      out_item_q.set_end    <= finish && fin_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // Status towards the controller.
  always_comb begin
    sts_o.close_hit  = in_item_i.final_req || (fill_next == FW'(sdgp_pkg::GROUP_LEN));
    sts_o.merge_full = (nbits_sum >= sdgp_pkg::WORD_BITS);
    sts_o.last       = last_val;
    sts_o.last_q     = last_q;
    sts_o.word_done  = word_done;
    sts_o.out_free   = out_free;
  end

endmodule

@@ sv/second_diff_group_packer_top.sv @@
// Header: after the transfer that closes a group, the controller enters ST_HEAD and loads
// the header into the output register once it is free. Throughput: one sample per cycle
// while a group fills; closing a group takes a header step, a buffer read and a merge per
// value, and a step per packed word, and each emitted item waits while the output stalls.
// Reset: rst_ni clears control state at once; the group buffer is not cleared.
// ---------------------------------------------------------------------------
// Second-difference group packer top level
// Collects offset second differences into groups and emits, per group, a
// header with minimum and width code followed by MSB-first packed words.
// ---------------------------------------------------------------------------
module second_diff_group_packer_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  sdgp_pkg::sdgp_in_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output sdgp_pkg::sdgp_out_t out_item_o
);

  sdgp_pkg::sdgp_cmd_t cmd;
  sdgp_pkg::sdgp_sts_t sts;

  // Sequencing.
  sdgp_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  // Differencing, buffering and packing.
  sdgp_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_item_i  (in_item_i),
    .out_stall_i(out_stall_i),
    .out_valid_o(out_valid_o),
    .out_item_o (out_item_o),
    .cmd_i      (cmd),
    .sts_o      (sts)
  );

`ifndef SYNTHESIS
  // The output register is only loaded when it is free.
  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.head || cmd.word || cmd.flush) |-> (!out_valid_o || !out_stall_i))
    else $error("output register loaded while a stalled item is held");

  // No item is produced while samples are being taken.
  a_no_emit_while_collecting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> !(cmd.head || cmd.word || cmd.flush || cmd.merge))
    else $error("packing activity while collecting samples");

  // A transfer that closes a group stalls the input on the next cycle.
  a_close_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && sts.close_hit) |=> in_stall_o)
    else $error("input not stalled after a group closed");

  // The end of a data set is always the end of a group.
  a_set_end_group_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.set_end) |-> out_item_o.group_end)
    else $error("set end without group end");
`endif

endmodule

@@ tb/tb_second_diff_group_packer_top.sv @@
// ---------------------------------------------------------------------------
// Testbench for the second-difference group packer
// Feeds data sets of 16-bit samples through the valid/stall input channel,
// predicts every group header and packed word in a behavioural model of the
// differencing and packing, and compares each output transfer field by field
// while both channels idle, burst and hold off at random.
// ---------------------------------------------------------------------------
module tb_second_diff_group_packer_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CLK_HALF       = 6;
  localparam int unsigned RESET_CYCLES   = 11;
  localparam int unsigned RANDOM_SAMPLES = 300;
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned HOLD_SPACING   = 100;
  localparam int unsigned HOLD_COUNT     = 2;
  localparam int unsigned SETTLE_CYCLES  = 100;
  localparam int unsigned CYCLE_LIMIT    = 200000;

  // Receiver behaviour between long hold-offs.
  typedef enum int {
    RX_FREE,
    RX_LIGHT,
    RX_HEAVY,
    RX_PERIODIC
  } rx_mode_e;

  // Shapes of the sample sequence within one data set.
  typedef enum int {
    SHAPE_NOISE,
    SHAPE_SMOOTH,
    SHAPE_RAMP,
    SHAPE_FLAT,
    SHAPE_SWING
  } shape_e;

  // One queued sample; drain_first holds it back until all results are in.
  typedef struct packed {
    sdgp_pkg::sdgp_in_t item;
    logic               drain_first;
  } feed_t;

  logic                clk_i     = 1'b0;
  logic                rst_ni    = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  sdgp_pkg::sdgp_in_t  in_item   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  sdgp_pkg::sdgp_out_t out_item;

  second_diff_group_packer_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item)
  );

  feed_t               sample_backlog[$];
  sdgp_pkg::sdgp_out_t packed_items_due[$];

  // Predictor state: differencing history and the group being collected.
  logic [sdgp_pkg::SAMPLE_W-1:0] last_sample = '0;
  logic [sdgp_pkg::SAMPLE_W-1:0] second_last = '0;
  logic [1:0]                    lead_seen   = '0;
  logic [sdgp_pkg::SAMPLE_W-1:0] group_codes [sdgp_pkg::GROUP_LEN];
  int unsigned                   codes_held  = 0;
  logic [sdgp_pkg::SAMPLE_W-1:0] code_lo     = sdgp_pkg::MIN_INIT;
  logic [sdgp_pkg::SAMPLE_W-1:0] code_hi     = sdgp_pkg::MAX_INIT;

  int unsigned mismatch_count = 0;
  int unsigned samples_taken  = 0;
  int unsigned sets_queued    = 0;
  int unsigned headers_seen   = 0;
  int unsigned words_seen     = 0;
  int unsigned cycle_count    = 0;
  int unsigned hold_left      = 0;
  int unsigned holds_done     = 0;
  int unsigned burst_left     = 0;
  int unsigned gap_left       = 0;
  int unsigned mode_left      = 0;
  int unsigned period         = 2;
  int unsigned phase          = 0;
  rx_mode_e    rx_mode        = RX_FREE;

  // Folds one accepted sample into the group and, when the group closes,
  // queues its header and packed words.
  task automatic fold_sample(input sdgp_pkg::sdgp_in_t s);
    logic [sdgp_pkg::SAMPLE_W-1:0] code;
    logic [sdgp_pkg::SAMPLE_W-1:0] spread;
    logic [sdgp_pkg::SAMPLE_W-1:0] offs;
    logic [63:0]                   acc;
    logic [63:0]                   padded;
    logic [sdgp_pkg::WORD_W-1:0]   words[$];
    int unsigned                   len;
    int unsigned                   wc;
    int unsigned                   nbits;
    int unsigned                   idx;
    sdgp_pkg::sdgp_out_t           it;
    if (lead_seen < sdgp_pkg::LEAD_DONE) begin
      code      = s.sample + sdgp_pkg::DIFF_OFFSET;
      lead_seen = lead_seen + 2'd1;
    end else begin
      code = s.sample - {last_sample[sdgp_pkg::SAMPLE_W-2:0], 1'b0} + second_last
             + sdgp_pkg::DIFF_OFFSET;
    end
    second_last = last_sample;
    last_sample = s.sample;
    group_codes[codes_held] = code;
    codes_held++;
    if (code < code_lo) code_lo = code;
    if (code > code_hi) code_hi = code;
    if (!s.final_req && codes_held < sdgp_pkg::GROUP_LEN) return;

    // Width code from the bit length of the range.
    spread = code_hi - code_lo;
    len = 0;
    while (spread != '0) begin
      len++;
      spread = spread >> 1;
    end
    wc = (len != 0) ? len - 1 : 0;

    // Pack the offsets from the minimum, most significant bit first.
    acc   = '0;
    nbits = 0;
    for (idx = 0; idx < codes_held; idx++) begin
      offs  = group_codes[idx] - code_lo;
      acc   = (acc << (wc + 1)) | {48'd0, offs};
      nbits = nbits + wc + 1;
      if (nbits >= sdgp_pkg::WORD_W) begin
        words.push_back(acc[nbits-1 -: sdgp_pkg::WORD_W]);
        nbits = nbits - sdgp_pkg::WORD_W;
        acc   = acc & ((64'd1 << nbits) - 64'd1);
      end
    end
    if (nbits > 0) begin
      padded = acc << (sdgp_pkg::WORD_W - nbits);
      words.push_back(padded[sdgp_pkg::WORD_W-1:0]);
    end

    it            = '0;
    it.kind       = sdgp_pkg::KIND_HEADER;
    it.min_ref    = code_lo;
    it.width_code = wc[sdgp_pkg::WCODE_W-1:0];
    packed_items_due.push_back(it);
    for (idx = 0; idx < words.size(); idx++) begin
      it           = '0;
      it.kind      = sdgp_pkg::KIND_DATA;
      it.data_word = words[idx];
      it.group_end = (idx == words.size() - 1);
      it.set_end   = s.final_req && (idx == words.size() - 1);
      packed_items_due.push_back(it);
    end

    // The final mark starts a fresh data set.
    if (s.final_req) begin
      last_sample = '0;
      second_last = '0;
      lead_seen   = '0;
    end
    codes_held = 0;
    code_lo    = sdgp_pkg::MIN_INIT;
    code_hi    = sdgp_pkg::MAX_INIT;
  endtask

  // Compares one output transfer with the oldest expectation.
  task automatic check_item(input sdgp_pkg::sdgp_out_t got,
                            input sdgp_pkg::sdgp_out_t want);
    if (got.kind !== want.kind) begin
      $error("kind: expected %0d, got %0d", want.kind, got.kind);
      mismatch_count++;
    end
    if (got.min_ref !== want.min_ref) begin
      $error("min_ref: expected %h, got %h", want.min_ref, got.min_ref);
      mismatch_count++;
    end
    if (got.width_code !== want.width_code) begin
      $error("width_code: expected %0d, got %0d", want.width_code, got.width_code);
      mismatch_count++;
    end
    if (got.data_word !== want.data_word) begin
      $error("data_word: expected %h, got %h", want.data_word, got.data_word);
      mismatch_count++;
    end
    if (got.group_end !== want.group_end) begin
      $error("group_end: expected %0d, got %0d", want.group_end, got.group_end);
      mismatch_count++;
    end
    if (got.set_end !== want.set_end) begin
      $error("set_end: expected %0d, got %0d", want.set_end, got.set_end);
      mismatch_count++;
    end
  endtask

  task automatic queue_sample(input logic [sdgp_pkg::SAMPLE_W-1:0] v, input logic fin,
                              input logic drain);
    feed_t f;
    f.item.sample    = v;
    f.item.final_req = fin;
    f.drain_first    = drain;
    sample_backlog.push_back(f);
  endtask

  // Queues a whole data set of the given length and shape.
  task automatic queue_set(input int unsigned len, input shape_e shape, input logic drain);
    logic [sdgp_pkg::SAMPLE_W-1:0] v;
    logic [sdgp_pkg::SAMPLE_W-1:0] step;
    int unsigned                   spread_log;
    int unsigned                   k;
    v          = $urandom_range(65535, 0);
    step       = $urandom_range(65535, 0);
    spread_log = $urandom_range(8, 0);
    if (shape == SHAPE_FLAT && $urandom_range(1, 0) == 0) v = '0;
    for (k = 0; k < len; k++) begin
      case (shape)
        SHAPE_NOISE:  v = $urandom_range(65535, 0);
        SHAPE_SMOOTH: if (k != 0) begin
          v = v + 16'($urandom_range(2 << spread_log, 0)) - 16'(1 << spread_log);
        end
        SHAPE_RAMP:   if (k != 0) v = v + step;
        SHAPE_SWING:  v = ~v;
        default: ;
      endcase
      queue_sample(v, k == len - 1, drain && k == 0);
    end
    sets_queued++;
  endtask

  // Clock.
  initial begin
    forever #(CLK_HALF) clk_i = ~clk_i;
  end

  // Driver: offers queued samples in bursts, holding a stalled transfer steady.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_item  <= '0;
    end else begin
      if (in_valid && !in_stall) begin
        fold_sample(in_item);
        samples_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left != 0 && hold_left == 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (sample_backlog.size() != 0 &&
                     !(sample_backlog[0].drain_first && packed_items_due.size() != 0)) begin
          in_item  <= sample_backlog[0].item;
          in_valid <= 1'b1;
          void'(sample_backlog.pop_front());
          if (burst_left != 0) begin
            burst_left--;
          end else if ($urandom_range(5, 0) == 0) begin
            // A long stretch without idling.
            burst_left = $urandom_range(80, 40);
            gap_left   = 0;
          end else begin
            burst_left = $urandom_range(12, 1);
            gap_left   = $urandom_range(8, 1);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each output transfer and drives the receiver's stall.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid === 1'b1 && !out_stall) begin
        if (packed_items_due.size() == 0) begin
          $error("unexpected transfer: kind %0d ref %h wc %0d word %h",
                 out_item.kind, out_item.min_ref, out_item.width_code, out_item.data_word);
          mismatch_count++;
        end else begin
          if (out_item.kind == sdgp_pkg::KIND_HEADER) headers_seen++;
          else words_seen++;
          check_item(out_item, packed_items_due.pop_front());
        end
      end

      if (mode_left == 0) begin
        rx_mode   = rx_mode_e'($urandom_range(3, 0));
        mode_left = $urandom_range(200, 32);
        period    = $urandom_range(5, 2);
      end else begin
        mode_left--;
      end
      phase = (phase + 1 >= period) ? 0 : phase + 1;

      // Long hold-offs so that the block fills and stalls its input.
      if (hold_left == 0 && holds_done < HOLD_COUNT &&
          samples_taken >= HOLD_SPACING * (holds_done + 1)) begin
        hold_left = HOLD_CYCLES;
        holds_done++;
      end

      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (rx_mode)
          RX_FREE:  out_stall <= 1'b0;
          RX_LIGHT: out_stall <= ($urandom_range(99, 0) < 25);
          RX_HEAVY: out_stall <= ($urandom_range(99, 0) < 75);
          default:  out_stall <= (phase == 0);
        endcase
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, packed_items_due.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    int unsigned random_count;
    int unsigned len;
    int unsigned set_index;
    shape_e      shape;

    // Directed part: a single-sample set, both extremes, a flat group,
    // the widest swing and values around the offset.
    queue_sample(16'h0000, 1'b1, 1'b0);
    queue_sample(16'hFFFF, 1'b0, 1'b0);
    queue_sample(16'h0000, 1'b1, 1'b0);
    queue_sample(16'h0000, 1'b0, 1'b0);
    queue_sample(16'h0000, 1'b0, 1'b0);
    queue_sample(16'h0000, 1'b0, 1'b0);
    queue_sample(16'h0000, 1'b1, 1'b0);
    queue_sample(16'h0000, 1'b0, 1'b0);
    queue_sample(16'hFFFF, 1'b0, 1'b0);
    queue_sample(16'h0000, 1'b0, 1'b0);
    queue_sample(16'hFFFF, 1'b0, 1'b0);
    queue_sample(16'h0000, 1'b1, 1'b0);
    queue_sample(16'h8000, 1'b0, 1'b0);
    queue_sample(16'h7FFF, 1'b0, 1'b0);
    queue_sample(16'h1234, 1'b1, 1'b0);
    queue_sample(16'hFFFF, 1'b0, 1'b0);
    queue_sample(16'hFFFF, 1'b0, 1'b0);
    queue_sample(16'hFFFF, 1'b1, 1'b0);
    sets_queued = 6;

    // Random data sets: short ones, exactly one or two full groups, one over or
    // under a boundary and arbitrary lengths; some wait for the block to drain.
    random_count = 0;
    set_index    = 0;
    while (random_count < RANDOM_SAMPLES) begin
      case ($urandom_range(9, 0))
        0, 1, 2: len = $urandom_range(4, 1);
        3:       len = sdgp_pkg::GROUP_LEN;
        4:       len = 2 * sdgp_pkg::GROUP_LEN;
        5:       len = ($urandom_range(1, 0) != 0) ? sdgp_pkg::GROUP_LEN + 1
                                                   : sdgp_pkg::GROUP_LEN - 1;
        default: len = $urandom_range(70, 5);
      endcase
      shape = shape_e'($urandom_range(4, 0));
      queue_set(len, shape, set_index == 0 || set_index == 12);
      random_count += len;
      set_index++;
    end

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (sample_backlog.size() != 0 || in_valid) @(posedge clk_i);
    while (packed_items_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("%0d samples in %0d data sets sent, %0d headers and %0d words checked",
             samples_taken, sets_queued, headers_seen, words_seen);
    $display("receiver hold-offs: %0d, cycles run: %0d", holds_done, cycle_count);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
